[rtl/pxbl_pkg.sv]
// Shared types, register codes and helpers for the ARGB8888 to RGB565 pixel blend core.
package pxbl_pkg;

  // Blend mode register codes
  typedef enum logic [1:0] {
    MODE_REPLACE = 2'd0,
    MODE_KEY     = 2'd1,
    MODE_BLEND   = 2'd2,
    MODE_NONE    = 2'd3
  } blend_mode_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLEND_MODE = 2'd0;
  localparam logic [1:0] CFG_DEST_565   = 2'd1;
  localparam logic [1:0] CFG_TRANS_KEY  = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Alpha extremes
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // Request payload: one source pixel and the destination pixel read back
  typedef struct packed {
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;
  } pxbl_in_t;

  // Result payload
  typedef struct packed {
    logic [31:0] out_pixel;
    logic        write_enable;
  } pxbl_out_t;

  // Pack 8-bit channels to RGB565
  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

[rtl/pxbl_mix_lane.sv]
// One color channel of the alpha blend: (a*s + (256-a)*d) >> 8 over two register stages.
module pxbl_mix_lane (
  input  logic       clk_i,
  input  logic [7:0] alpha_i,
  input  logic [7:0] src_i,
  input  logic [7:0] dst_i,
  output logic [7:0] mix_o
);

  logic [8:0]  inv_alpha;
  logic [15:0] prod_s_d, prod_s_q;
  logic [16:0] prod_d_d, prod_d_q;
  logic [16:0] sum;
  logic [7:0]  mix_d, mix_q;

  // Form both weighted terms
  always_comb begin
    inv_alpha = 9'd256 - {1'b0, alpha_i};
    prod_s_d  = alpha_i * src_i;
    prod_d_d  = inv_alpha * {1'b0, dst_i};
  end

  // Add the terms and drop the fraction
  always_comb begin
    sum   = {1'b0, prod_s_q} + prod_d_q;
    mix_d = sum[15:8];
  end

  always_ff @(posedge clk_i) begin
    prod_s_q <= prod_s_d;
    prod_d_q <= prod_d_d;
    mix_q    <= mix_d;
  end

  assign mix_o = mix_q;

endmodule

[rtl/argb_pixel_blend_rgb565_core.sv]
// Top level of the ARGB8888 pixel blend core with RGB565 or 32-bit destination.
// The core takes one request (source and destination pixel) in every clock cycle:
// busy is never raised, and each request gives exactly one result on rsp_o, marked by
// done_o, after it has passed the pipeline registers in order: decode and unpack, the
// per-channel multipliers, the add-and-shift, and the output register. The
// receiver cannot stall the core, so results must be taken when done_o is high. Write
// the configuration registers only while no request is in flight.
module argb_pixel_blend_rgb565_core
  import pxbl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel
  input  logic                start,
  output logic                busy,
  input  pxbl_in_t            req_i,
  // Result channel
  output logic                done_o,
  output pxbl_out_t           rsp_o,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // Configuration registers
  blend_mode_e mode_q;
  logic        dest565_q;
  logic [31:0] key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_REPLACE;
      dest565_q <= 1'b1;
      key_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BLEND_MODE: mode_q    <= blend_mode_e'(cfg_wdata_i[1:0]);
        CFG_DEST_565:   dest565_q <= cfg_wdata_i[0];
        CFG_TRANS_KEY:  key_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: decode the mode and unpack the channels
  logic [7:0]  alpha, s_r, s_g, s_b;
  logic        we_d, blend_d;
  logic [31:0] res_d;
  logic [7:0]  d_r, d_g, d_b;

  always_comb begin
    alpha   = req_i.src_pixel[31:24];
    s_r     = req_i.src_pixel[23:16];
    s_g     = req_i.src_pixel[15:8];
    s_b     = req_i.src_pixel[7:0];
    we_d    = 1'b0;
    blend_d = 1'b0;
    res_d   = req_i.dst_pixel;

    if (dest565_q) begin
      d_r = {req_i.dst_pixel[15:11], 3'b000};
      d_g = {req_i.dst_pixel[10:5], 2'b00};
      d_b = {req_i.dst_pixel[4:0], 3'b000};
    end else begin
      d_r = req_i.dst_pixel[23:16];
      d_g = req_i.dst_pixel[15:8];
      d_b = req_i.dst_pixel[7:0];
    end

    unique case (mode_q)
      MODE_REPLACE: we_d = 1'b1;
      MODE_KEY: begin
        if (dest565_q) we_d = (alpha != ALPHA_CLEAR);
        else           we_d = (req_i.src_pixel != key_q);
      end
      MODE_BLEND: begin
        we_d    = (alpha != ALPHA_CLEAR);
        blend_d = (alpha != ALPHA_CLEAR) && (alpha != ALPHA_OPAQUE);
      end
      MODE_NONE: we_d = 1'b0;
      default: we_d = 1'b0;
    endcase

    // Copy of the source where written without a blend
    if (we_d) begin
      if (dest565_q) res_d = {16'h0000, pack565(s_r, s_g, s_b)};
      else           res_d = req_i.src_pixel;
    end
  end

  logic        s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic        s1_we_q, s2_we_q, s3_we_q;
  logic        s1_blend_q, s2_blend_q, s3_blend_q;
  logic        s1_565_q, s2_565_q, s3_565_q;
  logic [31:0] s1_res_q, s2_res_q, s3_res_q;
  logic [7:0]  s1_dsta_q, s2_dsta_q, s3_dsta_q;
  logic [7:0]  s1_alpha_q, s1_sr_q, s1_sg_q, s1_sb_q, s1_dr_q, s1_dg_q, s1_db_q;
  pxbl_out_t   out_d, out_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // Advance payload along the pipeline
  always_ff @(posedge clk_i) begin
    s1_we_q    <= we_d;
    s1_blend_q <= blend_d;
    s1_565_q   <= dest565_q;
    s1_res_q   <= res_d;
    s1_dsta_q  <= req_i.dst_pixel[31:24];
    s1_alpha_q <= alpha;
    s1_sr_q    <= s_r;
    s1_sg_q    <= s_g;
    s1_sb_q    <= s_b;
    s1_dr_q    <= d_r;
    s1_dg_q    <= d_g;
    s1_db_q    <= d_b;

    s2_we_q    <= s1_we_q;
    s2_blend_q <= s1_blend_q;
    s2_565_q   <= s1_565_q;
    s2_res_q   <= s1_res_q;
    s2_dsta_q  <= s1_dsta_q;

    s3_we_q    <= s2_we_q;
    s3_blend_q <= s2_blend_q;
    s3_565_q   <= s2_565_q;
    s3_res_q   <= s2_res_q;
    s3_dsta_q  <= s2_dsta_q;

    out_q      <= out_d;
  end

  // Stages 2 and 3: per-channel blend
  logic [7:0] mix_r, mix_g, mix_b;

  pxbl_mix_lane u_lane_r (
    .clk_i  (clk_i),
    .alpha_i(s1_alpha_q),
    .src_i  (s1_sr_q),
    .dst_i  (s1_dr_q),
    .mix_o  (mix_r)
  );

  pxbl_mix_lane u_lane_g (
    .clk_i  (clk_i),
    .alpha_i(s1_alpha_q),
    .src_i  (s1_sg_q),
    .dst_i  (s1_dg_q),
    .mix_o  (mix_g)
  );

  pxbl_mix_lane u_lane_b (
    .clk_i  (clk_i),
    .alpha_i(s1_alpha_q),
    .src_i  (s1_sb_q),
    .dst_i  (s1_db_q),
    .mix_o  (mix_b)
  );

  // Select the blended or the passed pixel and repack
  always_comb begin
    out_d.write_enable = s3_we_q;
    if (s3_blend_q) begin
      if (s3_565_q) out_d.out_pixel = {16'h0000, pack565(mix_r, mix_g, mix_b)};
      else          out_d.out_pixel = {s3_dsta_q, mix_r, mix_g, mix_b};
    end else begin
      out_d.out_pixel = s3_res_q;
    end
  end

  assign done_o = out_valid_q;
  assign rsp_o  = out_q;

endmodule

[rtl/pxbl_checker.sv]
// Port-level checker for the pixel blend core, bound to the top level.
module pxbl_checker
  import pxbl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input pxbl_in_t  req_i,
  input logic      done_o,
  input pxbl_out_t rsp_o
);

  // Every request gives a result on done_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("request without result");

  // No result appears without a matching request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 4))
    else $error("result without request");

  // A result with no write returns the destination pixel unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.write_enable) |-> (rsp_o.out_pixel == $past(req_i.dst_pixel, 4)))
    else $error("skipped pixel altered");

  // The core never holds requests off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

endmodule

bind argb_pixel_blend_rgb565_core pxbl_checker u_pxbl_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .req_i (req_i),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

[dv/pxbl_blend_checker.sv]
// Checker for the pixel blend core: predicts each result from the observed requests and compares in order.
`timescale 1ns / 100ps
module pxbl_blend_checker
  import pxbl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  pxbl_in_t            req_i,
  input  logic                done_i,
  input  pxbl_out_t           rsp_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         pending_o,
  output int unsigned         fail_cnt_o
);

  localparam int unsigned ReportLimit = 10;

  // Shadow copy of the configuration registers
  blend_mode_e mode_q;
  logic        dest565_q;
  logic [31:0] key_q;

  // Predicted destination writes, oldest first
  pxbl_out_t   expected_pixels [$];
  int unsigned fail_cnt;

  // Mix one channel as (a*s + (256-a)*d) >> 8
  function automatic logic [7:0] mix_channel(input logic [7:0] a, input logic [7:0] s,
                                             input logic [7:0] d);
    int unsigned au, su, du;
    au = a;
    su = s;
    du = d;
    return 8'((au * su + (256 - au) * du) >> 8);
  endfunction

  // Reduce 8-bit channels to an RGB565 word
  function automatic logic [15:0] to_rgb565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    logic [31:0] word;
    word = ((32'(r) & 32'hF8) << 8) | ((32'(g) & 32'hFC) << 3) | ((32'(b) & 32'hF8) >> 3);
    return word[15:0];
  endfunction

  // Work out the new destination pixel and its write enable
  function automatic pxbl_out_t blend_pixel(input pxbl_in_t req);
    logic [7:0] a, sr, sg, sb, dr, dg, db;
    logic       mixing;
    pxbl_out_t  res;
    {a, sr, sg, sb} = req.src_pixel;
    res.out_pixel    = req.dst_pixel;
    res.write_enable = 1'b0;
    // Unpack the destination channels
    if (dest565_q) begin
      dr = {req.dst_pixel[15:11], 3'b000};
      dg = {req.dst_pixel[10:5], 2'b00};
      db = {req.dst_pixel[4:0], 3'b000};
    end else begin
      dr = req.dst_pixel[23:16];
      dg = req.dst_pixel[15:8];
      db = req.dst_pixel[7:0];
    end
    // Decide whether the destination gets written
    case (mode_q)
      MODE_REPLACE: res.write_enable = 1'b1;
      MODE_KEY: begin
        res.write_enable = dest565_q ? (a != ALPHA_CLEAR) : (req.src_pixel != key_q);
      end
      MODE_BLEND: res.write_enable = (a != ALPHA_CLEAR);
      default: res.write_enable = 1'b0;
    endcase
    mixing = (mode_q == MODE_BLEND) && (a != ALPHA_OPAQUE);
    if (res.write_enable) begin
      if (mixing) begin
        sr = mix_channel(a, sr, dr);
        sg = mix_channel(a, sg, dg);
        sb = mix_channel(a, sb, db);
      end
      if (dest565_q) begin
        res.out_pixel = {16'h0000, to_rgb565(sr, sg, sb)};
      end else if (mixing) begin
        res.out_pixel = {req.dst_pixel[31:24], sr, sg, sb};
      end else begin
        res.out_pixel = req.src_pixel;
      end
    end
    return res;
  endfunction

  // Track registers, queue predictions and check results
  always @(posedge clk_i or negedge rst_ni) begin
    pxbl_out_t exp_res;
    if (!rst_ni) begin
      mode_q    <= MODE_REPLACE;
      dest565_q <= 1'b1;
      key_q     <= '0;
      expected_pixels.delete();
      fail_cnt   = 0;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      // Check the result leaving the core this cycle
      if (done_i) begin
        if (expected_pixels.size() == 0) begin
          if (fail_cnt < ReportLimit) begin
            $display("%0t: result with no request pending: pixel %h we %b",
                     $realtime, rsp_i.out_pixel, rsp_i.write_enable);
          end
          fail_cnt++;
        end else begin
          exp_res = expected_pixels.pop_front();
          if (rsp_i.out_pixel !== exp_res.out_pixel ||
              rsp_i.write_enable !== exp_res.write_enable) begin
            if (fail_cnt < ReportLimit) begin
              $display("%0t: mismatch: expected pixel %h we %b, got pixel %h we %b",
                       $realtime, exp_res.out_pixel, exp_res.write_enable,
                       rsp_i.out_pixel, rsp_i.write_enable);
            end
            fail_cnt++;
          end
        end
      end
      // Predict the request taken this cycle
      if (start_i && !busy_i) begin
        expected_pixels.push_back(blend_pixel(req_i));
      end
      // Follow register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLEND_MODE: mode_q    <= blend_mode_e'(cfg_wdata_i[1:0]);
          CFG_DEST_565:   dest565_q <= cfg_wdata_i[0];
          CFG_TRANS_KEY:  key_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o  <= expected_pixels.size();
      fail_cnt_o <= fail_cnt;
    end
  end

endmodule

[dv/tb.sv]
// Testbench top for the pixel blend core: drives requests and register writes, gives the verdict.
`timescale 1ns / 100ps
module tb;
  import pxbl_pkg::*;

  localparam int unsigned RandomItems = 1700;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  pxbl_in_t            req;
  logic                done;
  pxbl_out_t           rsp;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  int unsigned pending;
  int unsigned fail_cnt;
  int unsigned idle_cycles;
  int unsigned sent;
  bit          no_gaps;

  argb_pixel_blend_rgb565_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .done_o     (done),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  pxbl_blend_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req),
    .done_i     (done),
    .rsp_i      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pending_o  (pending),
    .fail_cnt_o (fail_cnt)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one request and hold it until the core takes it
  task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
    start <= 1'b1;
    req   <= '{src_pixel: src, dst_pixel: dst};
    do @(posedge clk); while (busy);
  endtask

  // Insert a random gap between requests, mostly short
  task automatic idle_gap();
    int unsigned r, gap;
    if (no_gaps) return;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write all three registers while the core is empty
  task automatic configure(input blend_mode_e mode, input logic dest, input logic [31:0] key);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_BLEND_MODE;
    cfg_wdata <= CfgDataW'(mode);
    @(posedge clk);
    cfg_idx   <= CFG_DEST_565;
    cfg_wdata <= CfgDataW'(dest);
    @(posedge clk);
    cfg_idx   <= CFG_TRANS_KEY;
    cfg_wdata <= key;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random source pixel, biased toward the alpha extremes; hit returns the key itself
  function automatic logic [31:0] rand_src(input logic [31:0] key, input bit hit);
    logic [7:0] a;
    if (hit) return key;
    case ($urandom_range(0, 9))
      0: a = ALPHA_CLEAR;
      1: a = ALPHA_OPAQUE;
      2: a = 8'h01;
      3: a = 8'hFE;
      default: a = 8'($urandom);
    endcase
    return {a, 24'($urandom)};
  endfunction

  // Stimulus
  initial begin
    int unsigned phase, count;
    blend_mode_e mode;
    logic        dest;
    logic [31:0] key;
    bit          hit;
    start     <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    no_gaps = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: replace into an RGB565 destination
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    // Key mode on RGB565 tests only source alpha
    configure(MODE_KEY, 1'b1, 32'h00FF_FFFF);
    send_pixel(32'h00FF_FFFF, 32'h1234_ABCD);
    send_pixel(32'h0100_0000, 32'hFFFF_FFFF);
    // Blend into RGB565: opaque, clear, mid and near-extreme alpha
    configure(MODE_BLEND, 1'b1, 32'hFFFF_FFFF);
    send_pixel(32'hFF12_3456, 32'hFFFF_0000);
    send_pixel(32'h0012_3456, 32'hA5A5_5A5A);
    send_pixel(32'h80FF_FFFF, 32'hFFFF_0000);
    send_pixel(32'h0100_FF00, 32'h0000_FFFF);
    send_pixel(32'hFEFF_00FF, 32'hFFFF_07E0);
    // No-write mode keeps the destination
    configure(MODE_NONE, 1'b1, 32'h0000_0000);
    send_pixel(32'hFFFF_FFFF, 32'h89AB_CDEF);
    // 32-bit destination: replace, then key hit and misses
    configure(MODE_REPLACE, 1'b0, 32'hDEAD_BEEF);
    send_pixel(32'h0123_4567, 32'hFFFF_FFFF);
    configure(MODE_KEY, 1'b0, 32'hDEAD_BEEF);
    send_pixel(32'hDEAD_BEEF, 32'h1111_1111);
    send_pixel(32'hDEAD_BEEE, 32'h1111_1111);
    send_pixel(32'h0000_0000, 32'h1111_1111);
    // Blend into 32-bit: destination alpha byte must survive
    configure(MODE_BLEND, 1'b0, 32'h0000_0000);
    send_pixel(32'hFF80_4020, 32'hC0FF_FFFF);
    send_pixel(32'h0080_4020, 32'hC0FF_FFFF);
    send_pixel(32'h80FF_00FF, 32'hFF00_FF00);
    send_pixel(32'h01FF_FFFF, 32'h7F00_0000);
    send_pixel(32'hFE00_0000, 32'h80FF_FFFF);
    configure(MODE_NONE, 1'b0, 32'hFFFF_FFFF);
    send_pixel(32'h1234_5678, 32'h9ABC_DEF0);

    // Random phases, each under its own register setting
    phase = 0;
    sent  = 0;
    while (sent < RandomItems) begin
      if (phase < 8) begin
        mode = blend_mode_e'(phase[1:0]);
        dest = phase[2];
      end else begin
        count = $urandom_range(0, 5);
        mode  = (count >= 4) ? MODE_BLEND : blend_mode_e'(count[1:0]);
        dest  = 1'($urandom_range(0, 1));
      end
      case (phase % 3)
        0: key = 32'h0000_0000;
        1: key = 32'hFFFF_FFFF;
        default: key = $urandom;
      endcase
      configure(mode, dest, key);
      no_gaps = ($urandom_range(0, 4) == 0);
      count   = $urandom_range(40, 100);
      repeat (count) begin
        hit = (mode == MODE_KEY) && !dest && ($urandom_range(0, 3) == 0);
        send_pixel(rand_src(key, hit), $urandom);
        sent++;
        idle_gap();
        // Hold off once mid-run until the pipeline is empty
        if (sent == RandomItems / 2) drain();
      end
      phase++;
    end

    // Let the pipeline empty, then give the verdict
    drain();
    repeat (DrainCycles) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((start && !busy) || done || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
